// ===== hdl/sse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sse_pkg
// shared widths and register indexes for the squared sampson error block
// ----------------------------------------------------------------------------
package sse_pkg;

    localparam int RAY_W   = 24;
    localparam int COEF_W  = 16;
    localparam int ROW_W   = 48;
    localparam int CFG_W   = 48;
    localparam int RES_W   = 48;
    localparam int LINE_W  = 42;   // e*r products summed over three terms
    localparam int DOT_W   = 67;   // r2 . l, signed
    localparam int NUM_W   = 132;  // (r2 . l)^2
    localparam int DEN_W   = 84;   // sum of four 41-bit-magnitude squares
    localparam int DVS_W   = 92;   // denominator shifted by 8

    localparam logic [1:0] REG_E_ROW0 = 2'd0;
    localparam logic [1:0] REG_E_ROW1 = 2'd1;
    localparam logic [1:0] REG_E_ROW2 = 2'd2;

endpackage

// ===== hdl/sampson_epipolar_error_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sampson_epipolar_error_top
// squared sampson error of one ray correspondence against a 3x3 matrix
// ----------------------------------------------------------------------------
// Takes one correspondence per clock while the output is not stalled and
// returns its squared Sampson error through the arithmetic front end
// (products, sums, squares, an overflow compare over seven register stages)
// and a one-bit-per-stage divider of 49 register stages (an input stage and
// 48 quotient bit stages). A stall on the output freezes the whole
// pipeline; the input stall is then raised. Matrix rows are to be written
// through the register port while idle; the block does not enforce it.
module sampson_epipolar_error_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [1:0]                           cfg_index,
    input  logic [sse_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [sse_pkg::RAY_W-1:0]     ray1_x,
    input  logic signed [sse_pkg::RAY_W-1:0]     ray1_y,
    input  logic signed [sse_pkg::RAY_W-1:0]     ray1_z,
    input  logic signed [sse_pkg::RAY_W-1:0]     ray2_x,
    input  logic signed [sse_pkg::RAY_W-1:0]     ray2_y,
    input  logic signed [sse_pkg::RAY_W-1:0]     ray2_z,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [sse_pkg::RES_W-1:0]            squared_error,
    output logic                                 degenerate
);

    localparam int RW = sse_pkg::RAY_W;
    localparam int CW = sse_pkg::COEF_W;
    localparam int PW = RW + CW;   // 40-bit product

    logic [sse_pkg::ROW_W-1:0] row_reg [3];
    logic adv;
    logic div_valid;

    // global stall: output buffer holds when its item is not taken
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= '0;
            row_reg[1] <= '0;
            row_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sse_pkg::REG_E_ROW0: row_reg[0] <= cfg_data;
                sse_pkg::REG_E_ROW1: row_reg[1] <= cfg_data;
                sse_pkg::REG_E_ROW2: row_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    function automatic logic signed [CW-1:0] coef(input logic [sse_pkg::ROW_W-1:0] r,
                                                   input int c);
        coef = r[c*CW +: CW];
    endfunction

    // stage 1: nine e*r1 products, six r2*e products, register r2
    logic [6:0] vld_reg;
    logic signed [PW-1:0] lp_reg [3][3];
    logic signed [PW-1:0] d0p_reg [3];
    logic signed [PW-1:0] d1p_reg [3];
    logic signed [RW-1:0] r2_s1_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[5:0], in_valid};
        end
    end

    logic signed [RW-1:0] r1 [3];
    logic signed [RW-1:0] r2 [3];
    assign r1[0] = ray1_x;
    assign r1[1] = ray1_y;
    assign r1[2] = ray1_z;
    assign r2[0] = ray2_x;
    assign r2[1] = ray2_y;
    assign r2[2] = ray2_z;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    lp_reg[i][j] <= coef(row_reg[i], j) * r1[j];
                end
                d0p_reg[i]   <= coef(row_reg[i], 0) * r2[i];
                d1p_reg[i]   <= coef(row_reg[i], 1) * r2[i];
                r2_s1_reg[i] <= r2[i];
            end
        end
    end

    // stage 2: line l, d0, d1
    localparam int LW = sse_pkg::LINE_W;
    logic signed [LW-1:0] l_reg [3];
    logic signed [LW-1:0] d0_reg;
    logic signed [LW-1:0] d1_reg;
    logic signed [RW-1:0] r2_s2_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                l_reg[i] <= LW'(lp_reg[i][0]) + LW'(lp_reg[i][1]) + LW'(lp_reg[i][2]);
                r2_s2_reg[i] <= r2_s1_reg[i];
            end
            d0_reg <= LW'(d0p_reg[0]) + LW'(d0p_reg[1]) + LW'(d0p_reg[2]);
            d1_reg <= LW'(d1p_reg[0]) + LW'(d1p_reg[1]) + LW'(d1p_reg[2]);
        end
    end

    // stage 3: r2*l products and magnitudes for squares
    localparam int MW = LW - 1;
    localparam int QW = LW + RW;
    logic signed [QW-1:0] np_reg [3];
    logic [MW-1:0] m_reg [4];

    function automatic logic [MW-1:0] mag(input logic signed [LW-1:0] v);
        mag = v[LW-1] ? MW'(-v) : MW'(v);
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                np_reg[i] <= r2_s2_reg[i] * l_reg[i];
            end
            m_reg[0] <= mag(d0_reg);
            m_reg[1] <= mag(d1_reg);
            m_reg[2] <= mag(l_reg[0]);
            m_reg[3] <= mag(l_reg[1]);
        end
    end

    // stage 4: dot sum magnitude, four squares (41x41 split as halves)
    localparam int DW = sse_pkg::DOT_W;
    localparam int TW = DW - 1;
    localparam int SW = 2 * MW;
    localparam int ML = (MW + 1) / 2;
    localparam int MH = MW - ML;
    logic [TW-1:0] t_reg;
    logic [2*MH-1:0]  sqh_reg [4];
    logic [MH+ML-1:0] sqm_reg [4];
    logic [2*ML-1:0]  sql_reg [4];
    logic signed [DW-1:0] dot;

    assign dot = DW'(np_reg[0]) + DW'(np_reg[1]) + DW'(np_reg[2]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg <= dot[DW-1] ? TW'(-dot) : TW'(dot);
            for (int i = 0; i < 4; i++)
            begin
                sqh_reg[i] <= (2*MH)'(m_reg[i][MW-1:ML]) * (2*MH)'(m_reg[i][MW-1:ML]);
                sqm_reg[i] <= (MH+ML)'(m_reg[i][MW-1:ML]) * (MH+ML)'(m_reg[i][ML-1:0]);
                sql_reg[i] <= (2*ML)'(m_reg[i][ML-1:0]) * (2*ML)'(m_reg[i][ML-1:0]);
            end
        end
    end

    // stage 5: split square of t, square assembly
    localparam int HW = (TW + 1) / 2;
    localparam int NW = sse_pkg::NUM_W;
    localparam int EW = sse_pkg::DEN_W;
    logic [2*HW-1:0] phh_reg;
    logic [2*HW:0]   phl_reg;
    logic [2*HW-1:0] pll_reg;
    logic [SW-1:0]   sq_reg [4];
    logic [HW-1:0]   th;
    logic [HW-1:0]   tl;

    assign th = HW'(t_reg >> HW);
    assign tl = t_reg[HW-1:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            phh_reg <= (2*HW)'(th) * (2*HW)'(th);
            phl_reg <= (2*HW+1)'((2*HW)'(th) * (2*HW)'(tl)) << 1;
            pll_reg <= (2*HW)'(tl) * (2*HW)'(tl);
            for (int i = 0; i < 4; i++)
            begin
                sq_reg[i] <= (SW'(sqh_reg[i]) << (2*ML)) + (SW'(sqm_reg[i]) << (ML+1))
                           + SW'(sql_reg[i]);
            end
        end
    end

    // stage 6: numerator and denominator assembly
    logic [NW-1:0] num_reg;
    logic [EW-1:0] den6_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_reg  <= (NW'(phh_reg) << (2*HW)) + (NW'(phl_reg) << HW) + NW'(pll_reg);
            den6_reg <= EW'(sq_reg[0]) + EW'(sq_reg[1]) + EW'(sq_reg[2]) + EW'(sq_reg[3]);
        end
    end

    // stage 7: overflow and zero checks against d << 56
    localparam int VW = sse_pkg::DVS_W;
    localparam int LMW = EW + 8 + sse_pkg::RES_W;
    logic [NW-1:0]  num7_reg;
    logic [VW-1:0]  dvs7_reg;
    logic           ovf7_reg;
    logic           dg7_reg;
    logic [LMW-1:0] lim;

    assign lim = LMW'(den6_reg) << (8 + sse_pkg::RES_W);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num7_reg <= num_reg;
            dvs7_reg <= VW'(den6_reg) << 8;
            dg7_reg  <= (den6_reg == '0);
            ovf7_reg <= (LMW'(num_reg) >= lim);
        end
    end

    logic [sse_pkg::RES_W-1:0] quot;
    logic ovf;
    logic dg;

    sse_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (vld_reg[6]),
        .in_num    (num7_reg),
        .in_dvs    (dvs7_reg),
        .in_ovf    (ovf7_reg),
        .in_degen  (dg7_reg),
        .out_valid (div_valid),
        .out_quot  (quot),
        .out_ovf   (ovf),
        .out_degen (dg)
    );

    assign out_valid     = div_valid;
    assign squared_error = (ovf || dg) ? '1 : quot;
    assign degenerate    = dg;

endmodule

// ===== hdl/sse_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sse_divider
// pipelined restoring divider, one quotient bit per stage, with stall
// ----------------------------------------------------------------------------
module sse_divider
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic                            in_valid,
    input  logic [sse_pkg::NUM_W-1:0]       in_num,
    input  logic [sse_pkg::DVS_W-1:0]       in_dvs,
    input  logic                            in_ovf,
    input  logic                            in_degen,
    output logic                            out_valid,
    output logic [sse_pkg::RES_W-1:0]       out_quot,
    output logic                            out_ovf,
    output logic                            out_degen
);

    localparam int N  = sse_pkg::RES_W;
    localparam int RW = sse_pkg::NUM_W;
    localparam int VW = sse_pkg::DVS_W;
    localparam int XW = VW + N;   // divisor shifted by up to N-1 with a spare bit

    logic [N:0]                    vld_reg;
    logic [RW-1:0]                 rem_reg  [N+1];
    logic [VW-1:0]                 dvs_reg  [N+1];
    logic [N-1:0]                  quot_reg [N+1];
    logic [N:0]                    ovf_reg;
    logic [N:0]                    dg_reg;
    logic [XW-1:0]                 shifted  [N];
    logic [N-1:0]                  take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[N-1:0], in_valid};
        end
    end

    // stage k decides quotient bit N-1-k against divisor << (N-1-k)
    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            shifted[k] = XW'(dvs_reg[k]) << (N - 1 - k);
            take[k]    = (XW'(rem_reg[k]) >= shifted[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0]  <= in_num;
            dvs_reg[0]  <= in_dvs;
            quot_reg[0] <= '0;
            ovf_reg[0]  <= in_ovf;
            dg_reg[0]   <= in_degen;
            for (int k = 0; k < N; k++)
            begin
                rem_reg[k+1]  <= take[k] ? RW'(XW'(rem_reg[k]) - shifted[k]) : rem_reg[k];
                quot_reg[k+1] <= quot_reg[k] | (take[k] ? (N'(1) << (N - 1 - k)) : '0);
                dvs_reg[k+1]  <= dvs_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
                dg_reg[k+1]   <= dg_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[N];
    assign out_quot  = quot_reg[N];
    assign out_ovf   = ovf_reg[N];
    assign out_degen = dg_reg[N];

endmodule
